/* sv/spc_pkg.sv */
// Shared widths, register and operand codes, and controller/datapath interface types.
package spc_pkg;

    localparam int INTEGRAL_WIDTH = 32;
    localparam int VEL_W          = 16;
    localparam int GAIN_W         = 16;
    localparam int CMD_W          = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

    // Multiplier operand selects; the six velocity components come first.
    localparam int SEL_W = 4;
    localparam logic [SEL_W-1:0] SEL_MX    = 4'd0;
    localparam logic [SEL_W-1:0] SEL_MY    = 4'd1;
    localparam logic [SEL_W-1:0] SEL_MZ    = 4'd2;
    localparam logic [SEL_W-1:0] SEL_TX    = 4'd3;
    localparam logic [SEL_W-1:0] SEL_TY    = 4'd4;
    localparam logic [SEL_W-1:0] SEL_TZ    = 4'd5;
    localparam logic [SEL_W-1:0] SEL_KP    = 4'd6;
    localparam logic [SEL_W-1:0] SEL_KI_LO = 4'd7;
    localparam logic [SEL_W-1:0] SEL_KI_HI = 4'd8;
    localparam logic [SEL_W-1:0] SEL_KD    = 4'd9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_ADD_SQ,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_SAVE_MEAS,
        OP_UPDATE,
        OP_ADD_ACC,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [SEL_W-1:0] sel;
    } t_dp_cmd;

    typedef struct packed {
        logic root_last;
    } t_dp_status;

endpackage

/* sv/speed_pid_controller_unit.sv */
// Top level of the vector-speed PID controller: sequencer plus datapath.
//
//  channel  direction  handshake                payload
//  in       sink       i_in_valid / o_in_ready  i_measured_vel_{x,y,z}, i_target_vel_{x,y,z}
//  out      source     o_out_valid / i_out_ready o_accel_command, o_command_saturated
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item is taken only while the sequencer is idle, so the next item is accepted only after
// the last one has finished. Each item runs through two 16-step square roots on the shared root
// unit and ten passes through the single 17 x 18 multiplier.
// Reset (synchronous, active low) zeroes the gains, integral and previous error.
// A result waiting in the output register does not block intake; a second finished item
// holds in the datapath until the first is taken. Config writes are always ready.
module speed_pid_controller_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [spc_pkg::VEL_W-1:0]   i_measured_vel_x,
    input  logic signed [spc_pkg::VEL_W-1:0]   i_measured_vel_y,
    input  logic signed [spc_pkg::VEL_W-1:0]   i_measured_vel_z,
    input  logic signed [spc_pkg::VEL_W-1:0]   i_target_vel_x,
    input  logic signed [spc_pkg::VEL_W-1:0]   i_target_vel_y,
    input  logic signed [spc_pkg::VEL_W-1:0]   i_target_vel_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [spc_pkg::CMD_W-1:0]   o_accel_command,
    output logic                               o_command_saturated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic signed [spc_pkg::GAIN_W-1:0]  i_cfg_data
);
    import spc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    spc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    spc_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_cfg_we            (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_measured_vel_x    (i_measured_vel_x),
        .i_measured_vel_y    (i_measured_vel_y),
        .i_measured_vel_z    (i_measured_vel_z),
        .i_target_vel_x      (i_target_vel_x),
        .i_target_vel_y      (i_target_vel_y),
        .i_target_vel_z      (i_target_vel_z),
        .o_accel_command     (o_accel_command),
        .o_command_saturated (o_command_saturated)
    );

endmodule

/* sv/spc_ctrl.sv */
// Sequencer for the speed PID: steps the datapath through squares, roots and gain products.
module spc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output spc_pkg::t_dp_cmd    o_cmd,
    input  spc_pkg::t_dp_status i_status
);
    import spc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ADD,
        S_ROOT_INIT,
        S_ROOT,
        S_SAVE_MEAS,
        S_UPDATE,
        S_PROD_MUL,
        S_PROD_ADD,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [SEL_W-1:0] r_sel, n_sel;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = OP_NONE;
        o_cmd.sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_sel    = SEL_MX;
                    n_state  = S_SQ_MUL;
                end
            end
            S_SQ_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_SQ_ADD;
            end
            S_SQ_ADD: begin
                o_cmd.op = OP_ADD_SQ;
                if (r_sel == SEL_MZ || r_sel == SEL_TZ) begin
                    n_state = S_ROOT_INIT;
                end else begin
                    n_sel   = r_sel + SEL_W'(1);
                    n_state = S_SQ_MUL;
                end
            end
            S_ROOT_INIT: begin
                o_cmd.op = OP_ROOT_INIT;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT_STEP;
                if (i_status.root_last) begin
                    n_state = (r_sel == SEL_MZ) ? S_SAVE_MEAS : S_UPDATE;
                end
            end
            S_SAVE_MEAS: begin
                o_cmd.op = OP_SAVE_MEAS;
                n_sel    = SEL_TX;
                n_state  = S_SQ_MUL;
            end
            S_UPDATE: begin
                o_cmd.op = OP_UPDATE;
                n_sel    = SEL_KP;
                n_state  = S_PROD_MUL;
            end
            S_PROD_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_PROD_ADD;
            end
            S_PROD_ADD: begin
                o_cmd.op = OP_ADD_ACC;
                if (r_sel == SEL_KD) begin
                    n_state = S_FINISH;
                end else begin
                    n_sel   = r_sel + SEL_W'(1);
                    n_state = S_PROD_MUL;
                end
            end
            S_FINISH: begin
                // hold until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_MX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_out_valid && !i_out_ready)
        |=> (r_state == S_FINISH && r_out_valid))
        else $error("finish overwrote a pending result");

    a_root_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT && i_status.root_last)
        |=> (r_state == S_SAVE_MEAS || r_state == S_UPDATE))
        else $error("root sequence did not exit after last step");

    a_prod_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROD_MUL) |-> (r_sel >= SEL_KP && r_sel <= SEL_KD))
        else $error("gain product issued with a velocity operand");

endmodule

/* sv/spc_dp.sv */
// Datapath: shared multiplier, bit-pair square root, saturating integral and PID sum.
module spc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spc_pkg::t_dp_cmd                    i_cmd,
    output spc_pkg::t_dp_status                 o_status,
    input  logic                                i_cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic signed [spc_pkg::GAIN_W-1:0]   i_cfg_data,
    input  logic signed [spc_pkg::VEL_W-1:0]    i_measured_vel_x,
    input  logic signed [spc_pkg::VEL_W-1:0]    i_measured_vel_y,
    input  logic signed [spc_pkg::VEL_W-1:0]    i_measured_vel_z,
    input  logic signed [spc_pkg::VEL_W-1:0]    i_target_vel_x,
    input  logic signed [spc_pkg::VEL_W-1:0]    i_target_vel_y,
    input  logic signed [spc_pkg::VEL_W-1:0]    i_target_vel_z,
    output logic signed [spc_pkg::CMD_W-1:0]    o_accel_command,
    output logic                                o_command_saturated
);
    import spc_pkg::*;

    localparam int IW       = INTEGRAL_WIDTH;
    localparam int HALF     = IW / 2;
    localparam int SUMSQ_W  = 2 * VEL_W;
    localparam int MAG_W    = SUMSQ_W / 2;
    localparam int STEP_W   = $clog2(SUMSQ_W / 2);
    localparam int ERR_W    = MAG_W + 1;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int MA_W     = GAIN_W + 1;
    localparam int MB_W     = (HALF + 1 > DERIV_W) ? HALF + 1 : DERIV_W;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int ACC_W    = IW + GAIN_W + 1;
    localparam int FRAC_W   = 8;
    localparam int VEL_IDX_W = 3;

    // architectural state
    logic signed [GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic signed [IW-1:0]      r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;

    // working registers
    logic signed [VEL_W-1:0]   r_vel [6];
    logic signed [PROD_W-1:0]  r_prod;
    logic [SUMSQ_W-1:0]        r_sumsq;
    logic [SUMSQ_W-1:0]        r_rem;
    logic [SUMSQ_W-1:0]        r_root;
    logic [STEP_W-1:0]         r_rstep;
    logic [MAG_W-1:0]          r_mag_meas;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DERIV_W-1:0] r_deriv;
    logic                      r_isat;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [CMD_W-1:0]   r_cmd;
    logic                      r_sat;

    logic signed [MA_W-1:0]    w_mul_a;
    logic signed [MB_W-1:0]    w_mul_b;
    logic [SUMSQ_W-1:0]        w_bit, w_trial;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [IW:0]        w_int_sum;
    logic                      w_int_ovf;
    logic signed [IW-1:0]      w_int_next;
    logic signed [DERIV_W-1:0] w_deriv;
    logic signed [ACC_W-1:0]   w_addend;
    logic signed [ACC_W-1:0]   w_round;
    logic signed [ACC_W-1:0]   w_quot;
    logic [ACC_W-CMD_W:0]      w_upper;
    logic                      w_cmd_ovf;
    logic signed [CMD_W-1:0]   w_cmd;
    logic                      w_cfg_hit;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.sel) inside
            SEL_MX, SEL_MY, SEL_MZ, SEL_TX, SEL_TY, SEL_TZ: begin
                w_mul_a = MA_W'(r_vel[i_cmd.sel[VEL_IDX_W-1:0]]);
                w_mul_b = MB_W'(r_vel[i_cmd.sel[VEL_IDX_W-1:0]]);
            end
            SEL_KP: begin
                w_mul_a = MA_W'(r_gain_p);
                w_mul_b = MB_W'(r_err);
            end
            SEL_KI_LO: begin
                w_mul_a = MA_W'(r_gain_i);
                w_mul_b = MB_W'(r_integral[HALF-1:0]);
            end
            SEL_KI_HI: begin
                w_mul_a = MA_W'(r_gain_i);
                w_mul_b = MB_W'($signed(r_integral[IW-1:HALF]));
            end
            SEL_KD: begin
                w_mul_a = MA_W'(r_gain_d);
                w_mul_b = MB_W'(r_deriv);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // one root bit per step: bit walks down two places at a time
    assign w_bit   = SUMSQ_W'(1) << {r_rstep, 1'b0};
    assign w_trial = r_root + w_bit;
    assign o_status.root_last = (r_rstep == '0);

    assign w_err      = ERR_W'($signed({1'b0, r_root[MAG_W-1:0]}))
                      - ERR_W'($signed({1'b0, r_mag_meas}));
    assign w_int_sum  = (IW + 1)'(r_integral) + (IW + 1)'(w_err);
    assign w_int_ovf  = (w_int_sum[IW] != w_int_sum[IW-1]);
    assign w_int_next = w_int_ovf ? (w_int_sum[IW] ? {1'b1, {(IW-1){1'b0}}}
                                                   : {1'b0, {(IW-1){1'b1}}})
                                  : w_int_sum[IW-1:0];
    assign w_deriv    = DERIV_W'(w_err) - DERIV_W'(r_prev_err);

    assign w_addend = (i_cmd.sel == SEL_KI_HI) ? (ACC_W'(r_prod) <<< HALF) : ACC_W'(r_prod);

    // round half up, then clamp to the command range
    assign w_round   = r_acc + ACC_W'(1 << (FRAC_W - 1));
    assign w_quot    = w_round >>> FRAC_W;
    assign w_upper   = w_quot[ACC_W-1:CMD_W-1];
    assign w_cmd_ovf = !((&w_upper) || (~|w_upper));
    assign w_cmd     = w_cmd_ovf ? (w_quot[ACC_W-1] ? {1'b1, {(CMD_W-1){1'b0}}}
                                                    : {1'b0, {(CMD_W-1){1'b1}}})
                                 : w_quot[CMD_W-1:0];

    assign w_cfg_hit = i_cfg_we && (i_cfg_index == CFG_GAIN_P
                                 || i_cfg_index == CFG_GAIN_I
                                 || i_cfg_index == CFG_GAIN_D);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (w_cfg_hit) begin
            unique case (i_cfg_index)
                CFG_GAIN_P: r_gain_p <= i_cfg_data;
                CFG_GAIN_I: r_gain_i <= i_cfg_data;
                CFG_GAIN_D: r_gain_d <= i_cfg_data;
                default: begin
                end
            endcase
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (i_cmd.op == OP_UPDATE) begin
            r_integral <= w_int_next;
            r_prev_err <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_vel[0] <= i_measured_vel_x;
                r_vel[1] <= i_measured_vel_y;
                r_vel[2] <= i_measured_vel_z;
                r_vel[3] <= i_target_vel_x;
                r_vel[4] <= i_target_vel_y;
                r_vel[5] <= i_target_vel_z;
                r_sumsq  <= '0;
            end
            OP_MUL: begin
                r_prod <= w_mul_a * w_mul_b;
            end
            OP_ADD_SQ: begin
                r_sumsq <= r_sumsq + r_prod[SUMSQ_W-1:0];
            end
            OP_ROOT_INIT: begin
                r_rem   <= r_sumsq;
                r_root  <= '0;
                r_rstep <= '1;
                r_sumsq <= '0;
            end
            OP_ROOT_STEP: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_rstep <= r_rstep - STEP_W'(1);
            end
            OP_SAVE_MEAS: begin
                r_mag_meas <= r_root[MAG_W-1:0];
            end
            OP_UPDATE: begin
                r_err   <= w_err;
                r_deriv <= w_deriv;
                r_isat  <= w_int_ovf;
                r_acc   <= '0;
            end
            OP_ADD_ACC: begin
                r_acc <= r_acc + w_addend;
            end
            OP_FINISH: begin
                r_cmd <= w_cmd;
                r_sat <= r_isat || w_cmd_ovf;
            end
            default: begin
            end
        endcase
    end

    assign o_accel_command     = r_cmd;
    assign o_command_saturated = r_sat;

    a_root_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ROOT_STEP && o_status.root_last)
        |=> (r_root[SUMSQ_W-1:MAG_W] == '0))
        else $error("square root exceeds magnitude width");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> (r_integral == '0 && r_prev_err == '0))
        else $error("gain write did not clear loop state");

endmodule

/* tb/tb_speed_pid_controller_unit.sv */
// Self-checking testbench for the vector-speed PID controller: predicted commands vs. results.
module tb_speed_pid_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam longint CMD_MAX       = (longint'(1) << (CMD_W - 1)) - 1;
    localparam longint CMD_MIN       = -CMD_MAX - 1;
    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     SETTLE_CYCLES = 80;

    typedef struct {
        logic signed [VEL_W-1:0] meas_x, meas_y, meas_z;
        logic signed [VEL_W-1:0] targ_x, targ_y, targ_z;
    } t_vel_tick;

    typedef struct {
        logic signed [CMD_W-1:0] accel;
        logic                    sat;
    } t_drive_cmd;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [VEL_W-1:0]    i_measured_vel_x = '0;
    logic signed [VEL_W-1:0]    i_measured_vel_y = '0;
    logic signed [VEL_W-1:0]    i_measured_vel_z = '0;
    logic signed [VEL_W-1:0]    i_target_vel_x = '0;
    logic signed [VEL_W-1:0]    i_target_vel_y = '0;
    logic signed [VEL_W-1:0]    i_target_vel_z = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [CMD_W-1:0]    o_accel_command;
    logic                       o_command_saturated;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic signed [GAIN_W-1:0]   i_cfg_data = '0;

    // controller copy: gains and loop memory
    logic signed [GAIN_W-1:0]           kp_m = '0;
    logic signed [GAIN_W-1:0]           ki_m = '0;
    logic signed [GAIN_W-1:0]           kd_m = '0;
    logic signed [INTEGRAL_WIDTH-1:0]   integral_m = '0;
    logic signed [17:0]                 prev_err_m = '0;

    t_drive_cmd expected_cmds[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         stall_left = 0;

    speed_pid_controller_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_measured_vel_x    (i_measured_vel_x),
        .i_measured_vel_y    (i_measured_vel_y),
        .i_measured_vel_z    (i_measured_vel_z),
        .i_target_vel_x      (i_target_vel_x),
        .i_target_vel_y      (i_target_vel_y),
        .i_target_vel_z      (i_target_vel_z),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_accel_command     (o_accel_command),
        .o_command_saturated (o_command_saturated),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired with %0d ticks pending", expected_cmds.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // floor of the square root of the sum of squares, Q8.8 magnitude
    function automatic longint speed_of(logic signed [VEL_W-1:0] a, logic signed [VEL_W-1:0] b,
                                        logic signed [VEL_W-1:0] c);
        logic [31:0] rem;
        logic [31:0] root;
        logic [31:0] probe;
        longint      sq;
        sq = longint'(a) * a + longint'(b) * b + longint'(c) * c;
        rem = sq[31:0];
        root = '0;
        probe = 32'h4000_0000;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return longint'(root);
    endfunction

    // advance the loop memory by one tick and return the command it drives
    function automatic t_drive_cmd predict_drive(t_vel_tick t);
        longint     err;
        longint     deriv;
        longint     integ;
        longint     acc;
        longint     cmd;
        longint     lim;
        t_drive_cmd r;
        lim = (longint'(1) << (INTEGRAL_WIDTH - 1)) - 1;
        r.sat = 1'b0;
        err = speed_of(t.targ_x, t.targ_y, t.targ_z) - speed_of(t.meas_x, t.meas_y, t.meas_z);
        integ = longint'(integral_m) + err;
        if (integ > lim) begin
            integ = lim;
            r.sat = 1'b1;
        end else if (integ < -lim - 1) begin
            integ = -lim - 1;
            r.sat = 1'b1;
        end
        integral_m = integ[INTEGRAL_WIDTH-1:0];
        deriv = err - longint'(prev_err_m);
        prev_err_m = err[17:0];
        acc = longint'(kp_m) * err + longint'(ki_m) * integ + longint'(kd_m) * deriv;
        cmd = (acc + 128) >>> 8;
        if (cmd > CMD_MAX) begin
            cmd = CMD_MAX;
            r.sat = 1'b1;
        end else if (cmd < CMD_MIN) begin
            cmd = CMD_MIN;
            r.sat = 1'b1;
        end
        r.accel = cmd[CMD_W-1:0];
        return r;
    endfunction

    function automatic t_vel_tick make_tick(logic signed [VEL_W-1:0] mx, logic signed [VEL_W-1:0] my,
                                            logic signed [VEL_W-1:0] mz, logic signed [VEL_W-1:0] tx,
                                            logic signed [VEL_W-1:0] ty, logic signed [VEL_W-1:0] tz);
        t_vel_tick t;
        t.meas_x = mx;
        t.meas_y = my;
        t.meas_z = mz;
        t.targ_x = tx;
        t.targ_y = ty;
        t.targ_z = tz;
        return t;
    endfunction

    // mostly full-range or small vectors, plus target close to measured so the loop stays linear
    function automatic t_vel_tick random_tick();
        t_vel_tick   t;
        int unsigned shape;
        shape = $urandom_range(0, 9);
        if (shape < 4) begin
            t.meas_x = VEL_W'($urandom());
            t.meas_y = VEL_W'($urandom());
            t.meas_z = VEL_W'($urandom());
            t.targ_x = VEL_W'($urandom());
            t.targ_y = VEL_W'($urandom());
            t.targ_z = VEL_W'($urandom());
        end else if (shape < 7) begin
            t.meas_x = VEL_W'($urandom_range(0, 2047) - 1024);
            t.meas_y = VEL_W'($urandom_range(0, 2047) - 1024);
            t.meas_z = VEL_W'($urandom_range(0, 2047) - 1024);
            t.targ_x = VEL_W'($urandom_range(0, 2047) - 1024);
            t.targ_y = VEL_W'($urandom_range(0, 2047) - 1024);
            t.targ_z = VEL_W'($urandom_range(0, 2047) - 1024);
        end else begin
            t.meas_x = VEL_W'($urandom());
            t.meas_y = VEL_W'($urandom_range(0, 4095) - 2048);
            t.meas_z = VEL_W'($urandom());
            t.targ_x = t.meas_x + VEL_W'($urandom_range(0, 63) - 32);
            t.targ_y = t.meas_y + VEL_W'($urandom_range(0, 63) - 32);
            t.targ_z = t.meas_z + VEL_W'($urandom_range(0, 63) - 32);
        end
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // hold valid and payload until the tick is taken, then queue its command
    task automatic send_tick(input t_vel_tick t);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if ($urandom_range(0, 99) < send_idle_pct / 4)
            gap += $urandom_range(1, 70);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_measured_vel_x <= t.meas_x;
        i_measured_vel_y <= t.meas_y;
        i_measured_vel_z <= t.meas_z;
        i_target_vel_x   <= t.targ_x;
        i_target_vel_y   <= t.targ_y;
        i_target_vel_z   <= t.targ_z;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        expected_cmds.insert(expected_cmds.size(), predict_drive(t));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic signed [GAIN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN_P: kp_m = val;
            CFG_GAIN_I: ki_m = val;
            CFG_GAIN_D: kd_m = val;
            default: ;
        endcase
        // a write to a mapped gain also clears the loop memory
        if (idx == CFG_GAIN_P || idx == CFG_GAIN_I || idx == CFG_GAIN_D) begin
            integral_m = '0;
            prev_err_m = '0;
        end
        @(posedge i_clk);
    endtask

    task automatic write_all_gains(input logic signed [GAIN_W-1:0] kp,
                                   input logic signed [GAIN_W-1:0] ki,
                                   input logic signed [GAIN_W-1:0] kd);
        wait_drained();
        write_gain(CFG_GAIN_P, kp);
        write_gain(CFG_GAIN_I, ki);
        write_gain(CFG_GAIN_D, kd);
    endtask

    // receiver: short random stalls plus occasional long ones that back up the output
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 999) < recv_stall_pct / 4) begin
            stall_left  <= $urandom_range(10, 150);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_drive_cmd want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch($sformatf("command %0d with no tick pending", o_accel_command));
            end else begin
                want = expected_cmds.pop_front();
                if (o_accel_command !== want.accel)
                    report_mismatch($sformatf("accel_command got %0d want %0d",
                                              o_accel_command, want.accel));
                if (o_command_saturated !== want.sat)
                    report_mismatch($sformatf("command_saturated got %b want %b",
                                              o_command_saturated, want.sat));
            end
        end
    end

    // gains still at reset: command stays zero while the integral changes
    task automatic test_reset_gains();
        send_tick(make_tick(0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000));
        send_tick(make_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0));
    endtask

    // smallest gain exposes the round-half-up step at both signs
    task automatic test_rounding();
        wait_drained();
        write_gain(CFG_GAIN_P, 16'sd1);
        send_tick(make_tick(0, 0, 0, 128, 0, 0));
        send_tick(make_tick(128, 0, 0, 0, 0, 0));
        send_tick(make_tick(129, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 127, 0, 0));
    endtask

    task automatic test_field_extremes();
        wait_drained();
        write_gain(CFG_GAIN_P, 16'sh0100);
        send_tick(make_tick(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_tick(make_tick(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000));
        send_tick(make_tick(16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0));
        send_tick(make_tick(0, 16'sh7FFF, 0, 16'sh7FFF, 0, 0));
        send_tick(make_tick(0, 0, 0, -16'sd1, 16'sd1, -16'sd1));
        send_tick(make_tick(16'shFF00, 16'sh0F0F, 16'shF0F0, 16'sh5555, 16'shAAAA, 16'sh00FF));
    endtask

    // integral and derivative terms, and a write to the unmapped index that must not clear them
    task automatic test_loop_memory();
        wait_drained();
        write_gain(CFG_GAIN_I, 16'sh0100);
        write_gain(CFG_GAIN_D, 16'sh0100);
        send_tick(make_tick(0, 0, 0, 256, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 512, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 0, 0, -16'sd1024));
        wait_drained();
        write_gain(CFG_UNMAPPED, 16'sh7FFF);
        send_tick(make_tick(0, 300, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, 40, 30, 0));
        wait_drained();
        write_gain(CFG_GAIN_I, 16'sh7FFF);
        write_gain(CFG_GAIN_D, 16'sh8000);
        send_tick(make_tick(0, 0, 0, 0, 0, 1));
        send_tick(make_tick(0, 0, 0, 0, 0, 2));
    endtask

    task automatic test_random_ticks(input logic signed [GAIN_W-1:0] kp,
                                     input logic signed [GAIN_W-1:0] ki,
                                     input logic signed [GAIN_W-1:0] kd,
                                     input int send_pct, input int recv_pct, input int count);
        write_all_gains(kp, ki, kd);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            send_tick(random_tick());
    endtask

    initial begin
        logic signed [GAIN_W-1:0] g_p;
        logic signed [GAIN_W-1:0] g_i;
        logic signed [GAIN_W-1:0] g_d;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_gains();
        test_rounding();
        test_field_extremes();
        test_loop_memory();
        test_random_ticks(16'sh0100, 16'sh0004, 16'sh0080, 0, 0, 110);
        g_p = GAIN_W'($urandom_range(0, 2048) - 1024);
        g_i = GAIN_W'($urandom_range(0, 64) - 32);
        g_d = GAIN_W'($urandom_range(0, 2048) - 1024);
        test_random_ticks(g_p, g_i, g_d, 52, 0, 110);
        test_random_ticks(16'sh8000, 16'sh7FFF, 16'sh8000, 0, 52, 110);
        g_p = GAIN_W'($urandom());
        g_i = GAIN_W'($urandom());
        g_d = GAIN_W'($urandom());
        test_random_ticks(g_p, g_i, g_d, 7, 7, 110);
        test_random_ticks(16'sh7FFF, 16'sh8000, 16'sh7FFF, 52, 52, 40);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
